// File: hdl/fla_pkg.sv
package fla_pkg;

  localparam int MAX_UNITS    = 4096;
  localparam int LIST_ENTRIES = 16;

  // Field and storage widths
  localparam int ADDR_W = 12;
  localparam int LEN_W  = 13;
  localparam int IDX_W  = $clog2(LIST_ENTRIES);
  localparam int NUM_W  = IDX_W + 1;

  // Actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED     = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOCATED = 2'd2;
  localparam logic [1:0] ST_FULL          = 2'd3;

  // Index register operations
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_CLEAR = 3'd1;
  localparam logic [2:0] IDX_TOP   = 3'd2;
  localparam logic [2:0] IDX_INC   = 3'd3;
  localparam logic [2:0] IDX_DEC   = 3'd4;

  // Configuration register addresses (word index)
  localparam logic REG_POOL_UNITS = 1'b0;

  typedef struct packed {
    logic       load;        // capture the accepted item
    logic [2:0] idx_op;
    logic       first_alloc; // carve from offset 0
    logic       alloc_take;  // take the block at idx
    logic       free_take;   // release the record at idx
    logic       shift_free;  // close the gap in the free list
    logic       shift_used;  // close the gap in the record list
    logic       set_status;
    logic [1:0] status;
    logic       out_load;    // move the result to the output register
  } fla_cmd_t;

  typedef struct packed {
    logic is_free;
    logic cnt_zero;
    logic used_full;
    logic used_empty;
    logic free_empty;
    logic free_full;
    logic first_fits;
    logic fit;
    logic exact_drop;
    logic idx_zero;
    logic last_used;
    logic addr_hit;
    logic merge;
    logic end_free;
    logic end_used;
  } fla_stat_t;

endpackage

// File: hdl/fla_req_if.sv
interface fla_req_if;
  import fla_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [LEN_W-1:0]  count;
  logic [ADDR_W-1:0] address;

  modport source (output valid, action, count, address, input ready);
  modport sink   (input valid, action, count, address, output ready);
endinterface

// File: hdl/fla_rsp_if.sv
interface fla_rsp_if;
  import fla_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_start;
  logic [1:0]        status;

  modport source (output valid, block_start, status, input ready);
  modport sink   (input valid, block_start, status, output ready);
endinterface

// File: hdl/fla_datapath.sv
module fla_datapath
  import fla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fla_cmd_t          cmd_i,
  output fla_stat_t         stat_o,
  input  logic [LEN_W-1:0]  pool_units_i,
  input  logic              action_i,
  input  logic [LEN_W-1:0]  count_i,
  input  logic [ADDR_W-1:0] address_i,
  output logic [ADDR_W-1:0] block_start_o,
  output logic [1:0]        status_o
);

  // Free list (start may reach the pool size, so it keeps the full length width)
  logic [LEN_W-1:0]  fs_q [LIST_ENTRIES];
  logic [LEN_W-1:0]  fl_q [LIST_ENTRIES];
  logic [NUM_W-1:0]  fe_q;
  // Allocation records
  logic [ADDR_W-1:0] us_q [LIST_ENTRIES];
  logic [LEN_W-1:0]  ul_q [LIST_ENTRIES];
  logic [NUM_W-1:0]  ue_q;

  logic              act_q;
  logic [LEN_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] addr_q;
  logic [NUM_W-1:0]  idx_q;
  logic [ADDR_W-1:0] res_start_q;
  logic [1:0]        res_status_q;
  logic [ADDR_W-1:0] out_start_q;
  logic [1:0]        out_status_q;

  logic [IDX_W-1:0]  ix;
  logic [IDX_W-1:0]  ix_prev;
  logic [IDX_W-1:0]  fe_ix;
  logic [IDX_W-1:0]  ue_ix;
  logic [LEN_W-1:0]  pool;
  logic [LEN_W-1:0]  cur_fs;
  logic [LEN_W-1:0]  cur_fl;
  logic [ADDR_W-1:0] cur_us;
  logic [LEN_W-1:0]  cur_ul;
  logic [LEN_W-1:0]  rec_end;

  assign ix      = idx_q[IDX_W-1:0];
  assign ix_prev = ix - 1'b1;
  assign fe_ix   = fe_q[IDX_W-1:0];
  assign ue_ix   = ue_q[IDX_W-1:0];
  assign pool    = (pool_units_i > LEN_W'(MAX_UNITS)) ? LEN_W'(MAX_UNITS) : pool_units_i;
  assign cur_fs  = fs_q[ix];
  assign cur_fl  = fl_q[ix];
  assign cur_us  = us_q[ix];
  assign cur_ul  = ul_q[ix];
  assign rec_end = {1'b0, cur_us} + cur_ul;

  // Status toward the controller
  always_comb begin
    stat_o.is_free    = (act_q == ACT_FREE);
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.used_full  = (ue_q == NUM_W'(LIST_ENTRIES));
    stat_o.used_empty = (ue_q == '0);
    stat_o.free_empty = (fe_q == '0);
    stat_o.free_full  = (fe_q == NUM_W'(LIST_ENTRIES));
    stat_o.first_fits = (cnt_q <= pool);
    stat_o.fit        = (cur_fl >= cnt_q);
    stat_o.exact_drop = (fe_q > NUM_W'(1)) && (cur_fl == cnt_q);
    stat_o.idx_zero   = (idx_q == '0);
    stat_o.last_used  = ((idx_q + 1'b1) >= ue_q);
    stat_o.addr_hit   = (cur_us == addr_q);
    stat_o.merge      = (fe_q != '0) && (fs_q[0] == rec_end);
    stat_o.end_free   = (idx_q >= fe_q);
    stat_o.end_used   = (idx_q >= ue_q);
  end

  // Request, index and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q       <= action_i;
      cnt_q       <= count_i;
      addr_q      <= address_i;
      res_start_q <= '0;
    end
    if (cmd_i.alloc_take) res_start_q <= cur_fs[ADDR_W-1:0];
    if (cmd_i.set_status) res_status_q <= cmd_i.status;
    case (cmd_i.idx_op)
      IDX_CLEAR: idx_q <= '0;
      IDX_TOP:   idx_q <= fe_q - 1'b1;
      IDX_INC:   idx_q <= idx_q + 1'b1;
      IDX_DEC:   idx_q <= idx_q - 1'b1;
      default:   idx_q <= idx_q;
    endcase
    if (cmd_i.out_load) begin
      out_start_q  <= res_start_q;
      out_status_q <= res_status_q;
    end
  end

  // List contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.first_alloc) begin
      us_q[0] <= '0;
      ul_q[0] <= cnt_q;
      fs_q[0] <= cnt_q;
      fl_q[0] <= pool - cnt_q;
    end
    if (cmd_i.alloc_take) begin
      us_q[ue_ix] <= cur_fs[ADDR_W-1:0];
      ul_q[ue_ix] <= cnt_q;
      if (!stat_o.exact_drop) begin
        fs_q[ix] <= cur_fs + cnt_q;
        fl_q[ix] <= cur_fl - cnt_q;
      end
    end
    if (cmd_i.free_take) begin
      if (stat_o.merge) begin
        fs_q[0] <= {1'b0, cur_us};
        fl_q[0] <= fl_q[0] + cur_ul;
      end else begin
        fs_q[fe_ix] <= {1'b0, cur_us};
        fl_q[fe_ix] <= cur_ul;
      end
    end
    // Move entry idx down by one
    if (cmd_i.shift_free && !stat_o.end_free) begin
      fs_q[ix_prev] <= cur_fs;
      fl_q[ix_prev] <= cur_fl;
    end
    if (cmd_i.shift_used && !stat_o.end_used) begin
      us_q[ix_prev] <= cur_us;
      ul_q[ix_prev] <= cur_ul;
    end
  end

  // Entry counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q <= '0;
      ue_q <= '0;
    end else begin
      if (cmd_i.first_alloc) begin
        fe_q <= NUM_W'(1);
        ue_q <= NUM_W'(1);
      end
      if (cmd_i.alloc_take) ue_q <= ue_q + 1'b1;
      if (cmd_i.free_take && !stat_o.merge) fe_q <= fe_q + 1'b1;
      if (cmd_i.shift_free && stat_o.end_free) fe_q <= fe_q - 1'b1;
      if (cmd_i.shift_used && stat_o.end_used) ue_q <= ue_q - 1'b1;
    end
  end

  assign block_start_o = out_start_q;
  assign status_o      = out_status_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_q <= NUM_W'(LIST_ENTRIES)) else $error("free list count out of range");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ue_q <= NUM_W'(LIST_ENTRIES)) else $error("record count out of range");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.first_alloc |=> (fe_q == NUM_W'(1)) && (ue_q == NUM_W'(1)))
    else $error("first allocation did not set up both lists");

endmodule

// File: hdl/fla_ctrl.sv
module fla_ctrl
  import fla_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  fla_stat_t stat_i,
  output fla_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_ASRCH  = 3'd2;
  localparam logic [2:0] S_ASHIFT = 3'd3;
  localparam logic [2:0] S_FSRCH  = 3'd4;
  localparam logic [2:0] S_USHIFT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  // Sequence one item through search, update and shift
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (!stat_i.is_free) begin
          if (stat_i.cnt_zero) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_EXHAUSTED;
            state_d          = S_DONE;
          end else if (stat_i.used_full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_FULL;
            state_d          = S_DONE;
          end else if (stat_i.free_empty) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.first_alloc = stat_i.first_fits;
            cmd_o.status      = stat_i.first_fits ? ST_OK : ST_EXHAUSTED;
            state_d           = S_DONE;
          end else begin
            cmd_o.idx_op = IDX_TOP;
            state_d      = S_ASRCH;
          end
        end else if (stat_i.used_empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_ALLOCATED;
          state_d          = S_DONE;
        end else begin
          cmd_o.idx_op = IDX_CLEAR;
          state_d      = S_FSRCH;
        end
      end
      S_ASRCH: begin
        if (stat_i.fit) begin
          cmd_o.alloc_take = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_OK;
          cmd_o.idx_op     = IDX_INC;
          state_d          = stat_i.exact_drop ? S_ASHIFT : S_DONE;
        end else if (stat_i.idx_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_EXHAUSTED;
          state_d          = S_DONE;
        end else begin
          cmd_o.idx_op = IDX_DEC;
        end
      end
      S_ASHIFT: begin
        cmd_o.shift_free = 1'b1;
        cmd_o.idx_op     = IDX_INC;
        if (stat_i.end_free) state_d = S_DONE;
      end
      S_FSRCH: begin
        if (stat_i.addr_hit) begin
          cmd_o.set_status = 1'b1;
          if (!stat_i.merge && stat_i.free_full) begin
            cmd_o.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            cmd_o.free_take = 1'b1;
            cmd_o.status    = ST_OK;
            cmd_o.idx_op    = IDX_INC;
            state_d         = S_USHIFT;
          end
        end else if (stat_i.last_used) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_ALLOCATED;
          state_d          = S_DONE;
        end else begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_USHIFT: begin
        cmd_o.shift_used = 1'b1;
        cmd_o.idx_op     = IDX_INC;
        if (stat_i.end_used) state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    if (cmd_o.out_load) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// File: hdl/free_list_block_allocator_unit.sv
// An item decided in the start state goes straight to the done state; a list search may be
// followed by a shift that closes a gap before the result is loaded for output.
// Throughput: one item at a time; the search and shift walk one list entry per cycle.
// Reset: asynchronous, active low; both lists empty, pool_units = 256.
module free_list_block_allocator_unit
  import fla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fla_req_if.sink     req,
  fla_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LEN_W-1:0] pool_units_q;
  fla_cmd_t         cmd;
  fla_stat_t        stat;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POOL_UNITS) ? {{(32-LEN_W){1'b0}}, pool_units_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_units_q <= LEN_W'(256);
    end else if (psel && penable && pwrite && paddr[2] == REG_POOL_UNITS) begin
      pool_units_q <= pwdata[LEN_W-1:0];
    end
  end

  fla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fla_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pool_units_i  (pool_units_q),
    .action_i      (req.action),
    .count_i       (req.count),
    .address_i     (req.address),
    .block_start_o (rsp.block_start),
    .status_o      (rsp.status)
  );

endmodule
